// ===== rtl/mqb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqb_pkg
// Shared constants, codes and types of the multilevel queue bank.
// ----------------------------------------------------------------------------
package mqb_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int LEVELS      = 4;
  localparam int DATA_BITS   = 16;

  localparam int NUM_QUEUES    = 2 * LEVELS + 1;
  localparam int BLOCKED_INDEX = 2 * LEVELS;
  localparam int QID_W         = $clog2(NUM_QUEUES);
  localparam int PTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W        = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int LVL_TMP_W     = 5;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_SWAP = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    TGT_ACTIVE  = 2'd0,
    TGT_EXPIRED = 2'd1,
    TGT_BLOCKED = 2'd2
  } target_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One command as resolved against the descriptor table
  typedef struct packed {
    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] addr;
    status_e           status;
    logic [4:0]        occupancy;
    logic              deq_ok;
  } op_t;

endpackage

// ===== rtl/mqb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqb_req_if / mqb_rsp_if
// Valid/ready channels for commands and their results.
// ----------------------------------------------------------------------------
interface mqb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  target;
  logic [1:0]  level;
  logic [15:0] value;

  modport source (output valid, cmd, target, level, value, input ready);
  modport sink   (input valid, cmd, target, level, value, output ready);
endinterface

interface mqb_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] data_out;
  logic [4:0]  occupancy;

  modport source (output valid, status, data_out, occupancy, input ready);
  modport sink   (input valid, status, data_out, occupancy, output ready);
endinterface

// ===== rtl/mqb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqb_ram
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module mqb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mqb_desc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqb_desc
// Queue descriptor table: head, tail and count per queue, set-swap flag.
// Resolves a command to a memory access and its status.
// ----------------------------------------------------------------------------
module mqb_desc import mqb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  cmd_i,
  input  logic [1:0]  target_i,
  input  logic [1:0]  level_i,
  output op_t         op_o
);

  logic [PTR_W-1:0] head_q  [NUM_QUEUES];
  logic [PTR_W-1:0] tail_q  [NUM_QUEUES];
  logic [CNT_W-1:0] count_q [NUM_QUEUES];
  logic             first_active_q, first_active_d;

  logic [LVL_TMP_W-1:0] lvl;
  logic [QID_W-1:0]     qid;
  logic                 phys_second;
  logic [PTR_W-1:0]     head_sel, tail_sel, head_nxt, tail_nxt;
  logic [CNT_W-1:0]     count_sel, count_nxt;
  logic                 do_enq, do_deq;

  always_comb begin
    first_active_d = (cmd_i == CMD_SWAP) ? !first_active_q : first_active_q;

    // reduce level modulo LEVELS; level is below four
    lvl = LVL_TMP_W'(level_i);
    for (int i = 0; i < 3; i++) begin
      if (lvl >= LVL_TMP_W'(LEVELS)) begin
        lvl = lvl - LVL_TMP_W'(LEVELS);
      end
    end

    phys_second = (target_i == TGT_ACTIVE) ? !first_active_d : first_active_d;
    if (target_i >= TGT_BLOCKED) begin
      qid = QID_W'(BLOCKED_INDEX);
    end else begin
      qid = (phys_second ? QID_W'(LEVELS) : '0) + QID_W'(lvl);
    end

    head_sel  = head_q[qid];
    tail_sel  = tail_q[qid];
    count_sel = count_q[qid];

    head_nxt = (head_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_sel + 1'b1;
    tail_nxt = (tail_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_sel + 1'b1;

    do_enq = (cmd_i == CMD_ENQ) && (count_sel < CNT_W'(QUEUE_DEPTH));
    do_deq = (cmd_i == CMD_DEQ) && (count_sel != '0);

    count_nxt = count_sel;
    if (do_enq) begin
      count_nxt = count_sel + 1'b1;
    end else if (do_deq) begin
      count_nxt = count_sel - 1'b1;
    end
  end

  always_comb begin
    op_o.mem_en    = do_enq || do_deq;
    op_o.mem_we    = do_enq;
    op_o.addr      = ADDR_W'(qid) * ADDR_W'(QUEUE_DEPTH)
                   + ADDR_W'(do_enq ? tail_sel : head_sel);
    op_o.occupancy = 5'(count_nxt);
    op_o.deq_ok    = do_deq;
    op_o.status    = ST_OK;
    case (cmd_i)
      CMD_ENQ: if (!do_enq) op_o.status = ST_FULL;
      CMD_DEQ: if (!do_deq) op_o.status = ST_EMPTY;
      default: op_o.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_active_q <= 1'b1;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else if (accept_i) begin
      first_active_q <= first_active_d;
      count_q[qid]   <= count_nxt;
      if (do_enq) begin
        tail_q[qid] <= tail_nxt;
      end
      if (do_deq) begin
        head_q[qid] <= head_nxt;
      end
    end
  end

endmodule

// ===== rtl/multilevel_queue_bank_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_queue_bank_core
// Nine circular FIFOs (active set, expired set, blocked) in one entry RAM.
// ----------------------------------------------------------------------------
//  channel | dir | fields                          | accepted when
//  req_i   | in  | cmd, target, level, value       | valid && ready
//  rsp_o   | out | status, data_out, occupancy     | valid && ready
//
//  One command per cycle unless a result stalls; each result is valid the next cycle.
//  Descriptors update at the accept edge; the entry RAM is read or written
//  in the same cycle and its registered read data forms data_out.
//  A stalled result holds; the next command is taken in the cycle the
//  result is taken. Reset clears all descriptors at once, no clearing pass.
// ----------------------------------------------------------------------------
module multilevel_queue_bank_core import mqb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mqb_req_if.sink    req_i,
  mqb_rsp_if.source  rsp_o
);

  op_t              op;
  logic             accept;
  logic [DATA_BITS-1:0] rdata;

  logic             valid_q;
  status_e          status_q;
  logic [4:0]       occ_q;
  logic             deq_ok_q;

  assign req_i.ready = !valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  mqb_desc u_desc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (req_i.cmd),
    .target_i (req_i.target),
    .level_i  (req_i.level),
    .op_o     (op)
  );

  mqb_ram #(
    .DEPTH (NUM_QUEUES * QUEUE_DEPTH),
    .WIDTH (DATA_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (accept && op.mem_en),
    .we_i    (op.mem_we),
    .addr_i  (op.addr),
    .wdata_i (DATA_BITS'(req_i.value)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= op.status;
      occ_q    <= op.occupancy;
      deq_ok_q <= op.deq_ok;
    end
  end

  assign rsp_o.valid     = valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.occupancy = occ_q;
  assign rsp_o.data_out  = deq_ok_q ? 16'(rdata) : '0;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_o.valid)
    else $error("accepted command produced no result");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_EMPTY) |->
      (rsp_o.occupancy == '0 && rsp_o.data_out == '0))
    else $error("empty result with data or occupancy");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.cmd == CMD_ENQ && op.status == ST_FULL |=>
      rsp_o.occupancy == 5'(QUEUE_DEPTH))
    else $error("full result on a queue that is not full");

endmodule

// ===== tb/multilevel_queue_bank_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_queue_bank_core_tb
// Self-checking bench for the nine-queue bank. A shadow copy of the queues
// predicts status, dequeued word and occupancy for every accepted command.
// The bench runs directed corner cases, fill/drain rounds per target level,
// a biased random mix, a long result back-pressure stretch and a no-idle run.
// ----------------------------------------------------------------------------
module multilevel_queue_bank_core_tb;
  import mqb_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [1:0]  TGT_UNUSED  = 2'd3;
  localparam int          IDLE_PCT    = 27;
  localparam int          HOLD_CYCLES = 60;

  typedef struct packed {
    status_e     status;
    logic [15:0] data;
    logic [4:0]  occ;
  } bank_result_t;

  logic clk;
  logic rst_n;

  mqb_req_if req_if ();
  mqb_rsp_if rsp_if ();

  multilevel_queue_bank_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Shadow of the queue bank
  logic [DATA_BITS-1:0] qbank_mem [NUM_QUEUES][QUEUE_DEPTH];
  int                   qhead     [NUM_QUEUES];
  int                   qtail     [NUM_QUEUES];
  int                   qfill     [NUM_QUEUES];
  bit                   set0_active;

  bank_result_t pending_results[$];

  int  errors;
  int  cycles;
  int  n_cmds, n_enq, n_deq, n_full, n_empty, n_swap, n_nop, n_checked;
  bit  src_idle;
  bit  snk_idle;
  bit  hold_go;
  int  hold_count;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bank_result_t predict_bank_cmd(logic [1:0] op, logic [1:0] tgt,
                                                    logic [1:0] lvl, logic [15:0] val);
    bank_result_t r;
    int qi;
    r.status = ST_OK;
    r.data   = '0;
    if (op == CMD_SWAP) begin
      set0_active = !set0_active;
      n_swap++;
    end
    if (tgt == TGT_ACTIVE || tgt == TGT_EXPIRED)
      qi = (((tgt == TGT_ACTIVE) == set0_active) ? 0 : LEVELS) + int'(lvl) % LEVELS;
    else
      qi = BLOCKED_INDEX;
    case (op)
      CMD_ENQ: begin
        if (qfill[qi] >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          qbank_mem[qi][qtail[qi]] = val[DATA_BITS-1:0];
          qtail[qi] = (qtail[qi] + 1) % QUEUE_DEPTH;
          qfill[qi]++;
          n_enq++;
        end
      end
      CMD_DEQ: begin
        if (qfill[qi] == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.data = 16'(qbank_mem[qi][qhead[qi]]);
          qhead[qi] = (qhead[qi] + 1) % QUEUE_DEPTH;
          qfill[qi]--;
          n_deq++;
        end
      end
      CMD_SWAP: ;
      default: n_nop++;
    endcase
    r.occ = 5'(qfill[qi]);
    return r;
  endfunction

  // Offer one command and hold it until taken
  task automatic send_cmd(input logic [1:0] op, input logic [1:0] tgt,
                          input logic [1:0] lvl, input logic [15:0] val);
    while (src_idle && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.cmd    <= op;
    req_if.target <= tgt;
    req_if.level  <= lvl;
    req_if.value  <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.push_back(predict_bank_cmd(op, tgt, lvl, val));
    n_cmds++;
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go    = 1'b0;
      hold_count = HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count--;
      rsp_if.ready <= 1'b0;
    end else if (snk_idle) begin
      rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    bank_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected word: status=%0d data_out=%0h occupancy=%0d",
               rsp_if.status, rsp_if.data_out, rsp_if.occupancy);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.data_out !== want.data) begin
          $error("data_out: expected %0h, actual %0h", want.data, rsp_if.data_out);
          errors++;
        end
        if (rsp_if.occupancy !== want.occ) begin
          $error("occupancy: expected %0d, actual %0d", want.occ, rsp_if.occupancy);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_cmd(CMD_DEQ, TGT_ACTIVE, 2'd0, 16'h0000);
    send_cmd(CMD_DEQ, TGT_EXPIRED, 2'd3, 16'hFFFF);
    send_cmd(CMD_DEQ, TGT_BLOCKED, 2'd1, 16'h0000);
    send_cmd(CMD_DEQ, TGT_UNUSED, 2'd2, 16'h0000);
    send_cmd(CMD_ENQ, TGT_ACTIVE, 2'd3, 16'hFFFF);
    send_cmd(CMD_ENQ, TGT_ACTIVE, 2'd3, 16'h0000);
    send_cmd(CMD_ENQ, TGT_ACTIVE, 2'd0, 16'hA5A5);
    send_cmd(CMD_ENQ, TGT_BLOCKED, 2'd3, 16'h1234);
    // unused target lands in the blocked queue
    send_cmd(CMD_ENQ, TGT_UNUSED, 2'd1, 16'h5A5A);
    send_cmd(CMD_UNUSED, TGT_ACTIVE, 2'd3, 16'hFFFF);
    send_cmd(CMD_UNUSED, TGT_UNUSED, 2'd0, 16'h0000);
    send_cmd(CMD_SWAP, TGT_EXPIRED, 2'd3, 16'hFFFF);
    send_cmd(CMD_DEQ, TGT_EXPIRED, 2'd3, 16'h0000);
    send_cmd(CMD_DEQ, TGT_EXPIRED, 2'd3, 16'h0000);
    send_cmd(CMD_DEQ, TGT_EXPIRED, 2'd3, 16'h0000);
    send_cmd(CMD_ENQ, TGT_ACTIVE, 2'd3, 16'h8001);
    send_cmd(CMD_DEQ, TGT_BLOCKED, 2'd0, 16'h0000);
    send_cmd(CMD_DEQ, TGT_UNUSED, 2'd3, 16'h0000);
    send_cmd(CMD_SWAP, TGT_ACTIVE, 2'd0, 16'h0000);
    send_cmd(CMD_DEQ, TGT_ACTIVE, 2'd0, 16'h0000);
    send_cmd(CMD_DEQ, TGT_EXPIRED, 2'd3, 16'h0000);
    wait_drain();
  endtask

  // Fill each target level past full, then drain past empty; pointers wrap
  task automatic test_fill_drain();
    logic [1:0] tgt;
    int extra;
    for (int k = 0; k < NUM_QUEUES; k++) begin
      if (k < LEVELS) tgt = TGT_ACTIVE;
      else if (k < 2 * LEVELS) tgt = TGT_EXPIRED;
      else tgt = $urandom_range(1) ? TGT_BLOCKED : TGT_UNUSED;
      extra = $urandom_range(1, 3);
      for (int i = 0; i < QUEUE_DEPTH + extra; i++)
        send_cmd(CMD_ENQ, tgt, 2'(k), 16'($urandom));
      for (int i = 0; i < QUEUE_DEPTH + extra; i++)
        send_cmd(CMD_DEQ, tgt, 2'(k), 16'($urandom));
      if ($urandom_range(2) == 0)
        send_cmd(CMD_SWAP, 2'($urandom_range(3)), 2'($urandom), 16'($urandom));
    end
    wait_drain();
  endtask

  // Commands cluster on one hot queue per window so fills and empties recur
  task automatic run_mix(input int count);
    logic [1:0] op, tgt, lvl;
    logic [1:0] hot_tgt, hot_lvl;
    int pick, enq_pct;
    hot_tgt = '0;
    hot_lvl = '0;
    enq_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        hot_tgt = 2'($urandom_range(3));
        hot_lvl = 2'($urandom);
        enq_pct = $urandom_range(35, 70);
      end
      pick = $urandom_range(99);
      if (pick < 5) op = CMD_SWAP;
      else if (pick < 8) op = CMD_UNUSED;
      else op = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      if ($urandom_range(99) < 70) begin
        tgt = hot_tgt;
        lvl = hot_lvl;
      end else begin
        tgt = 2'($urandom_range(3));
        lvl = 2'($urandom);
      end
      send_cmd(op, tgt, lvl, 16'($urandom));
    end
  endtask

  task automatic test_random_mix();
    run_mix(600);
    wait_drain();
  endtask

  task automatic test_backpressure();
    hold_go = 1'b1;
    for (int i = 0; i < 30; i++)
      send_cmd($urandom_range(1) ? CMD_ENQ : CMD_DEQ, TGT_ACTIVE, 2'($urandom),
               16'($urandom));
    wait_drain();
  endtask

  task automatic test_no_idle();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    run_mix(150);
    wait_drain();
    src_idle = 1'b1;
    snk_idle = 1'b1;
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd   = CMD_ENQ;
    req_if.target = TGT_ACTIVE;
    req_if.level = '0;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    src_idle     = 1'b1;
    snk_idle     = 1'b1;
    hold_go      = 1'b0;
    hold_count   = 0;
    set0_active  = 1'b1;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      qhead[q] = 0;
      qtail[q] = 0;
      qfill[q] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_drain();
    test_random_mix();
    test_backpressure();
    test_no_idle();

    wait_drain();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    $display("Covered %0d commands, %0d results checked: %0d enqueued, %0d dequeued,",
             n_cmds, n_checked, n_enq, n_deq);
    $display("  %0d full drops, %0d empty dequeues, %0d swaps, %0d unused commands",
             n_full, n_empty, n_swap, n_nop);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
